// File: rtl/rtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header parser package
// Shared word types, header tracking struct and protocol constants.
// ----------------------------------------------------------------------------
package rtp_pkg;

    localparam logic [6:0]  FIXED_HEADER_BYTES = 7'd12;
    localparam logic [1:0]  RTP_VERSION        = 2'd2;
    localparam logic [16:0] POS_LIMIT          = 17'h10000;
    localparam logic [18:0] HEO_RESET          = 19'd12;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_packet;
    } t_in_word;

    typedef struct packed {
        logic        status;
        logic [1:0]  version;
        logic        padding_flag;
        logic        extension_flag;
        logic [3:0]  source_count;
        logic        marker;
        logic [6:0]  payload_type;
        logic [15:0] sequence_number;
        logic [31:0] timestamp;
        logic [31:0] ssrc;
        logic [15:0] payload_offset;
        logic [15:0] data_size;
    } t_out_word;

    typedef struct packed {
        logic [31:0] lead;
        logic [31:0] ts;
        logic [31:0] ssrc;
        logic [18:0] heo;
        logic [16:0] len;
        logic [6:0]  base;
        logic        ext;
        logic [7:0]  last_byte;
    } t_hdr;

endpackage

// File: rtl/rtp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP input register
// Holds one packet byte and hands it to the parse stage when it can advance.
// ----------------------------------------------------------------------------
module rtp_in_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  rtp_pkg::t_in_word i_in_data,
    output logic             o_in_stall,
    input  logic             i_out_free,
    output logic             o_go,
    output rtp_pkg::t_in_word o_word
);

    logic              r_valid;
    logic              n_valid;
    rtp_pkg::t_in_word r_word;
    logic              w_accept;

    assign o_go       = r_valid && (!r_word.end_of_packet || i_out_free);
    assign o_in_stall = r_valid && !o_go;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_word     = r_word;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_go) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= i_in_data;
        end
    end

    a_stall_only_on_blocked_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_word.end_of_packet && !i_out_free))
        else $error("input stalled without a blocked final word");

endmodule

// File: rtl/rtp_hdr_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header tracker
// Counts bytes, captures the fixed header and the extension length word,
// and works out where the header ends.
// ----------------------------------------------------------------------------
module rtp_hdr_track (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output rtp_pkg::t_hdr o_hdr
);

    logic [16:0] r_pos;
    logic [31:0] r_lead;
    logic [31:0] r_ts;
    logic [31:0] r_ssrc;
    logic [15:0] r_ewc;
    logic [18:0] r_heo;

    logic [16:0] n_pos;
    logic [31:0] n_lead;
    logic [31:0] n_ts;
    logic [31:0] n_ssrc;
    logic [15:0] n_ewc;
    logic [18:0] n_heo;

    logic [7:0]  w_b0;
    logic        w_ext;
    logic [6:0]  w_base;
    logic [16:0] w_base_w;

    always_comb begin
        n_lead = r_lead;
        n_ts   = r_ts;
        n_ssrc = r_ssrc;
        if (r_pos < 17'd4) begin
            case (r_pos[1:0])
                2'd0:    n_lead[31:24] = r_lead[31:24] | i_byte;
                2'd1:    n_lead[23:16] = r_lead[23:16] | i_byte;
                2'd2:    n_lead[15:8]  = r_lead[15:8] | i_byte;
                default: n_lead[7:0]   = r_lead[7:0] | i_byte;
            endcase
        end else if (r_pos < 17'd8) begin
            case (r_pos[1:0])
                2'd0:    n_ts[31:24] = r_ts[31:24] | i_byte;
                2'd1:    n_ts[23:16] = r_ts[23:16] | i_byte;
                2'd2:    n_ts[15:8]  = r_ts[15:8] | i_byte;
                default: n_ts[7:0]   = r_ts[7:0] | i_byte;
            endcase
        end else if (r_pos < 17'd12) begin
            case (r_pos[1:0])
                2'd0:    n_ssrc[31:24] = r_ssrc[31:24] | i_byte;
                2'd1:    n_ssrc[23:16] = r_ssrc[23:16] | i_byte;
                2'd2:    n_ssrc[15:8]  = r_ssrc[15:8] | i_byte;
                default: n_ssrc[7:0]   = r_ssrc[7:0] | i_byte;
            endcase
        end

        w_b0     = n_lead[31:24];
        w_ext    = w_b0[4];
        w_base   = rtp_pkg::FIXED_HEADER_BYTES + {1'b0, w_b0[3:0], 2'b00};
        w_base_w = {10'd0, w_base};

        n_ewc = r_ewc;
        n_heo = r_heo;
        if (r_pos == 17'd0) begin
            n_heo = {12'd0, w_base} + (w_ext ? 19'd4 : 19'd0);
        end else if (w_ext && (r_pos == w_base_w + 17'd2 || r_pos == w_base_w + 17'd3)) begin
            n_ewc = {r_ewc[7:0], i_byte};
            if (r_pos == w_base_w + 17'd3) begin
                n_heo = r_heo + {1'b0, n_ewc, 2'b00};
            end
        end

        n_pos = (r_pos < rtp_pkg::POS_LIMIT) ? r_pos + 17'd1 : r_pos;
    end

    assign o_hdr.lead      = n_lead;
    assign o_hdr.ts        = n_ts;
    assign o_hdr.ssrc      = n_ssrc;
    assign o_hdr.heo       = n_heo;
    assign o_hdr.len       = n_pos;
    assign o_hdr.base      = w_base;
    assign o_hdr.ext       = w_ext;
    assign o_hdr.last_byte = i_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_go && i_last)) begin
            r_pos  <= 17'd0;
            r_lead <= 32'd0;
            r_ts   <= 32'd0;
            r_ssrc <= 32'd0;
            r_ewc  <= 16'd0;
            r_heo  <= rtp_pkg::HEO_RESET;
        end else if (i_go) begin
            r_pos  <= n_pos;
            r_lead <= n_lead;
            r_ts   <= n_ts;
            r_ssrc <= n_ssrc;
            r_ewc  <= n_ewc;
            r_heo  <= n_heo;
        end
    end

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= rtp_pkg::POS_LIMIT)
        else $error("byte counter ran past its limit");

    a_heo_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_heo >= rtp_pkg::HEO_RESET)
        else $error("header end offset below the fixed header size");

endmodule

// File: rtl/rtp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP result stage
// Checks the finished packet, forms the result word and holds it until it
// is taken.
// ----------------------------------------------------------------------------
module rtp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  rtp_pkg::t_hdr     i_hdr,
    output logic              o_free,
    output logic              o_out_valid,
    output rtp_pkg::t_out_word o_out_data,
    input  logic              i_out_stall
);

    logic               r_valid;
    logic               n_valid;
    rtp_pkg::t_out_word r_data;
    rtp_pkg::t_out_word n_data;

    logic [7:0]  w_b0;
    logic [16:0] w_base_w;
    logic [15:0] w_size;
    logic        w_st;

    always_comb begin
        n_data   = '0;
        w_b0     = i_hdr.lead[31:24];
        w_base_w = {10'd0, i_hdr.base};
        w_size   = 16'd0;
        w_st     = 1'b0;
        if (i_hdr.len < {10'd0, rtp_pkg::FIXED_HEADER_BYTES}) begin
            w_st = 1'b1;
        end else begin
            n_data.version         = w_b0[7:6];
            n_data.padding_flag    = w_b0[5];
            n_data.extension_flag  = w_b0[4];
            n_data.source_count    = w_b0[3:0];
            n_data.marker          = i_hdr.lead[23];
            n_data.payload_type    = i_hdr.lead[22:16];
            n_data.sequence_number = i_hdr.lead[15:0];
            n_data.timestamp       = i_hdr.ts;
            n_data.ssrc            = i_hdr.ssrc;
            if (i_hdr.len[16] || w_b0[7:6] != rtp_pkg::RTP_VERSION
                    || w_base_w > i_hdr.len) begin
                w_st = 1'b1;
            end else if (i_hdr.ext && w_base_w + 17'd4 > i_hdr.len) begin
                w_st = 1'b1;
            end else if (i_hdr.heo > {2'd0, i_hdr.len}) begin
                w_st = 1'b1;
            end else begin
                n_data.payload_offset = i_hdr.heo[15:0];
                w_size = i_hdr.len[15:0] - i_hdr.heo[15:0];
                if (w_b0[5] && w_size != 16'd0) begin
                    if (i_hdr.last_byte == 8'd0 || {8'd0, i_hdr.last_byte} > w_size) begin
                        w_st = 1'b1;
                    end else begin
                        w_size = w_size - {8'd0, i_hdr.last_byte};
                    end
                end
                n_data.data_size = w_size;
            end
        end
        n_data.status = w_st;
        if (w_st) begin
            n_data.payload_offset = 16'd0;
            n_data.data_size      = 16'd0;
        end
    end

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result loaded over a word not yet taken");

    a_good_has_version: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data.status) |-> (r_data.version == rtp_pkg::RTP_VERSION))
        else $error("valid status with wrong version");

    a_good_offset_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data.status)
            |-> (r_data.payload_offset >= {9'd0, rtp_pkg::FIXED_HEADER_BYTES}))
        else $error("valid status with payload offset inside fixed header");

endmodule

// File: rtl/rtp_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header parser
// Parses an RTP fixed header from a byte stream and reports payload bounds.
// ----------------------------------------------------------------------------
// Input channel: one packet byte per word on i_in_data, with end_of_packet
// set on the final byte. A word is taken when i_in_valid is high and
// o_in_stall is low. Bytes may arrive in every cycle.
// Output channel: one result word per packet on o_out_data, taken when
// o_out_valid is high and i_out_stall is low.
// Throughput: one byte per cycle, except while a final byte waits for the
// result register. Each byte passes through the input register, then the
// header tracker updates its counters and capture registers and, on the
// final byte, the result register is loaded.
// While the receiver stalls, the held result stays put and non-final bytes
// keep flowing; only a final byte waits in the input register until the
// result register is free, and the input then stalls.
// Reset clears the byte counter, capture registers and both valid flags;
// the block is ready for a new packet as soon as reset is released.
// ----------------------------------------------------------------------------
module rtp_header_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  rtp_pkg::t_in_word  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output rtp_pkg::t_out_word o_out_data,
    input  logic               i_out_stall
);

    logic              w_go;
    logic              w_free;
    rtp_pkg::t_in_word w_word;
    rtp_pkg::t_hdr     w_hdr;

    rtp_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_out_free (w_free),
        .o_go       (w_go),
        .o_word     (w_word)
    );

    rtp_hdr_track u_hdr_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_byte  (w_word.packet_byte),
        .i_last  (w_word.end_of_packet),
        .o_hdr   (w_hdr)
    );

    rtp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_go && w_word.end_of_packet),
        .i_hdr       (w_hdr),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: verif/rtp_header_parser_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP header parser testbench
// Streams RTP packets into the parser one byte per word, with random idle
// cycles on the input and random stalls on the result side. A scoreboard
// tracks each packet's header as its bytes are accepted, predicts the
// result word, and checks every field of each result that leaves the parser.
// ----------------------------------------------------------------------------
module rtp_header_parser_test;

    localparam int MAX_PACKET_BYTES   = 65535;
    localparam int RANDOM_BYTES       = 550;
    localparam int MIN_RANDOM_PACKETS = 12;
    localparam int IDLE_LIMIT         = 2000;
    localparam int DRAIN_CYCLES       = 8;
    localparam int NO_CAP             = 1 << 20;

    class header_scoreboard;
        logic [16:0]        byte_count;
        logic [31:0]        lead_bytes;
        logic [31:0]        ts_bytes;
        logic [31:0]        ssrc_bytes;
        logic [15:0]        ext_words;
        logic [18:0]        hdr_end;
        logic [7:0]         last_byte;
        rtp_pkg::t_out_word pending_headers[$];
        int                 errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            byte_count = '0;
            lead_bytes = '0;
            ts_bytes   = '0;
            ssrc_bytes = '0;
            ext_words  = '0;
            hdr_end    = rtp_pkg::HEO_RESET;
            last_byte  = '0;
        endfunction

        function void take_byte(rtp_pkg::t_in_word w);
            int                 p;
            int                 base;
            int                 len;
            int                 off;
            int                 size;
            logic [7:0]         b;
            logic [7:0]         b0;
            logic               ext;
            logic               st;
            rtp_pkg::t_out_word r;
            b = w.packet_byte;
            p = int'(byte_count);
            if (p < 4) begin
                lead_bytes[31 - 8 * p -: 8] = b;
            end else if (p < 8) begin
                ts_bytes[31 - 8 * (p - 4) -: 8] = b;
            end else if (p < 12) begin
                ssrc_bytes[31 - 8 * (p - 8) -: 8] = b;
            end
            b0   = lead_bytes[31:24];
            ext  = b0[4];
            base = int'(rtp_pkg::FIXED_HEADER_BYTES) + 4 * int'(b0[3:0]);
            if (p == 0) begin
                hdr_end = 19'(base + (ext ? 4 : 0));
            end else if (ext && (p == base + 2 || p == base + 3)) begin
                ext_words = {ext_words[7:0], b};
                if (p == base + 3) begin
                    hdr_end = 19'(int'(hdr_end) + 4 * int'(ext_words));
                end
            end
            last_byte = b;
            if (byte_count < rtp_pkg::POS_LIMIT) begin
                byte_count = byte_count + 17'd1;
            end
            if (!w.end_of_packet) begin
                return;
            end
            r    = '0;
            len  = int'(byte_count);
            st   = 1'b0;
            off  = 0;
            size = 0;
            if (len < int'(rtp_pkg::FIXED_HEADER_BYTES)) begin
                st = 1'b1;
            end else begin
                r.version         = b0[7:6];
                r.padding_flag    = b0[5];
                r.extension_flag  = b0[4];
                r.source_count    = b0[3:0];
                r.marker          = lead_bytes[23];
                r.payload_type    = lead_bytes[22:16];
                r.sequence_number = lead_bytes[15:0];
                r.timestamp       = ts_bytes;
                r.ssrc            = ssrc_bytes;
                if (len > MAX_PACKET_BYTES || b0[7:6] != rtp_pkg::RTP_VERSION
                        || base > len) begin
                    st = 1'b1;
                end else if (ext && base + 4 > len) begin
                    st = 1'b1;
                end else if (int'(hdr_end) > len) begin
                    st = 1'b1;
                end else begin
                    off  = int'(hdr_end);
                    size = len - off;
                    if (b0[5] && size > 0) begin
                        if (last_byte == 8'd0 || int'(last_byte) > size) begin
                            st = 1'b1;
                        end else begin
                            size = size - int'(last_byte);
                        end
                    end
                end
            end
            r.status = st;
            if (!st) begin
                r.payload_offset = off[15:0];
                r.data_size      = size[15:0];
            end
            pending_headers.push_back(r);
            clear();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(rtp_pkg::t_out_word got);
            rtp_pkg::t_out_word want;
            if (pending_headers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, got %h", $time, got);
                return;
            end
            want = pending_headers.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("version", 32'(want.version), 32'(got.version));
            compare_field("padding_flag", 32'(want.padding_flag), 32'(got.padding_flag));
            compare_field("extension_flag", 32'(want.extension_flag),
                          32'(got.extension_flag));
            compare_field("source_count", 32'(want.source_count), 32'(got.source_count));
            compare_field("marker", 32'(want.marker), 32'(got.marker));
            compare_field("payload_type", 32'(want.payload_type), 32'(got.payload_type));
            compare_field("sequence_number", 32'(want.sequence_number),
                          32'(got.sequence_number));
            compare_field("timestamp", want.timestamp, got.timestamp);
            compare_field("ssrc", want.ssrc, got.ssrc);
            compare_field("payload_offset", 32'(want.payload_offset),
                          32'(got.payload_offset));
            compare_field("data_size", 32'(want.data_size), 32'(got.data_size));
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    rtp_pkg::t_in_word  i_in_data   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    rtp_pkg::t_out_word o_out_data;

    header_scoreboard sb = new();
    logic [7:0]       pkt_bytes[$];
    int               bytes_sent  = 0;
    int               idle_cycles = 0;

    rtp_header_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int draw_gap(int mode);
        if (mode == 0) begin
            return 0;
        end else if (mode == 1) begin
            return $urandom_range(0, 8);
        end
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    endfunction

    task automatic build_packet(input logic [1:0] ver, input logic pad_on, input logic ext_on,
                                input logic [3:0] cc, input int ext_len, input int body_len,
                                input int pad_value, input int max_len, input int fill);
        int i;
        pkt_bytes.delete();
        pkt_bytes.push_back({ver, pad_on, ext_on, cc});
        repeat (11) pkt_bytes.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
        repeat (4 * cc) pkt_bytes.push_back(8'($urandom));
        if (ext_on) begin
            pkt_bytes.push_back(8'($urandom));
            pkt_bytes.push_back(8'($urandom));
            pkt_bytes.push_back(8'(ext_len >> 8));
            pkt_bytes.push_back(8'(ext_len));
            for (i = 0; i < 4 * ext_len && pkt_bytes.size() < max_len; i++) begin
                pkt_bytes.push_back(8'($urandom));
            end
        end
        for (i = 0; i < body_len && pkt_bytes.size() < max_len; i++) begin
            pkt_bytes.push_back(8'($urandom));
        end
        if (pad_on && body_len > 0 && i == body_len && pad_value >= 0) begin
            pkt_bytes[pkt_bytes.size() - 1] = 8'(pad_value);
        end
        while (pkt_bytes.size() > max_len) begin
            void'(pkt_bytes.pop_back());
        end
    endtask

    task automatic send_packet(input int gap_mode);
        rtp_pkg::t_in_word w;
        int                i;
        int                gap;
        for (i = 0; i < pkt_bytes.size(); i++) begin
            w.packet_byte   = pkt_bytes[i];
            w.end_of_packet = (i == pkt_bytes.size() - 1);
            gap = draw_gap(gap_mode);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= w;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
            sb.take_byte(w);
            bytes_sent++;
        end
    endtask

    task automatic random_packet();
        logic [1:0] ver;
        logic       pad_on;
        logic       ext_on;
        logic [3:0] cc;
        int         ext_len;
        int         body_len;
        int         pad_value;
        int         max_len;
        int         kind;
        kind        = $urandom_range(0, 9);
        ver         = rtp_pkg::RTP_VERSION;
        pad_on      = ($urandom_range(0, 3) == 0);
        ext_on      = ($urandom_range(0, 2) == 0);
        cc          = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 2));
        ext_len     = $urandom_range(0, 3);
        body_len    = $urandom_range(0, 24);
        pad_value   = (body_len > 0) ? $urandom_range(1, body_len) : 0;
        max_len     = NO_CAP;
        case (kind)
            0: begin
                ver = 2'($urandom_range(0, 3));
            end
            1: begin
                if ($urandom_range(0, 3) == 0) begin
                    ext_on  = 1'b1;
                    ext_len = $urandom_range(0, 65535);
                    max_len = $urandom_range(12, 40);
                end else begin
                    max_len = $urandom_range(1, 12 + 4 * cc + (ext_on ? 4 + 4 * ext_len : 0)
                                                + body_len);
                end
            end
            2: begin
                pad_on    = 1'b1;
                body_len  = $urandom_range(1, 24);
                pad_value = $urandom_range(0, 1) ? 0 : $urandom_range(body_len + 1, 255);
            end
            3: begin
                ver       = 2'($urandom_range(0, 3));
                pad_value = -1;
                max_len   = $urandom_range(1, 16);
            end
            default: begin
            end
        endcase
        build_packet(ver, pad_on, ext_on, cc, ext_len, body_len, pad_value, max_len, -1);
        send_packet($urandom_range(0, 2));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("rtp_header_parser test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : result_sink
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = draw_gap($urandom_range(0, 2));
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_result(o_out_data);
        end
    end

    initial begin : stimulus
        int random_start;
        int random_packets;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_packet(rtp_pkg::RTP_VERSION, 0, 0, 0, 0, 0, -1, 1, 'hff);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 0, 0, 0, 0, 0, -1, 11, 'hff);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 0, 0, 0, 0, 0, -1, NO_CAP, 'hff);
        send_packet($urandom_range(0, 2));
        build_packet(2'd0, 0, 0, 0, 0, 8, -1, NO_CAP, 'h00);
        send_packet($urandom_range(0, 2));
        build_packet(2'd1, 0, 0, 0, 0, 8, -1, NO_CAP, -1);
        send_packet($urandom_range(0, 2));
        build_packet(2'd3, 1, 1, 15, 1, 8, 2, NO_CAP, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 0, 0, 15, 0, 4, -1, NO_CAP, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 0, 0, 15, 0, 0, -1, 40, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 0, 1, 0, 0, 0, -1, 14, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 0, 1, 0, 2, 0, -1, 20, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 0, 1, 3, 65535, 0, -1, 64, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 0, 1, 2, 3, 10, -1, NO_CAP, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 0, 1, 1, 1, 0, -1, NO_CAP, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 1, 0, 0, 0, 10, 0, NO_CAP, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 1, 0, 0, 0, 10, 11, NO_CAP, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 1, 0, 0, 0, 10, 10, NO_CAP, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 1, 0, 0, 0, 0, -1, NO_CAP, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 1, 0, 0, 0, 1, 1, NO_CAP, -1);
        send_packet($urandom_range(0, 2));
        build_packet(rtp_pkg::RTP_VERSION, 1, 1, 15, 1, 255, 255, NO_CAP, -1);
        send_packet($urandom_range(0, 2));

        random_start   = bytes_sent;
        random_packets = 0;
        while (bytes_sent - random_start < RANDOM_BYTES
                || random_packets < MIN_RANDOM_PACKETS) begin
            random_packet();
            random_packets++;
        end
        i_in_valid <= 1'b0;

        while (sb.pending_headers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("rtp_header_parser test passed");
        end else begin
            $display("rtp_header_parser test failed");
        end
        $finish;
    end

endmodule
